>>> sv/radix_string_to_unsigned_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radix string parser
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RADIX_STRING_TO_UNSIGNED_MACROS_SVH
`define RADIX_STRING_TO_UNSIGNED_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSTU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSTU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rstu_pkg.sv
// ----------------------------------------------------------------------------
// Radix string parser package
// Shared codes, character constants and structures of the parser.
// ----------------------------------------------------------------------------
package rstu_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FORMAT   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Radix selection codes.
  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  // Configuration register indexes.
  localparam logic CFG_RADIX = 1'b0;
  localparam logic CFG_WIDE  = 1'b1;

  localparam int CHAR_W = 8;
  localparam int ACC_W  = 64;
  localparam int NARROW_W = 32;
  // Product width: accumulator times at most sixteen, plus one digit.
  localparam int PROD_W = ACC_W + 4;

  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F   = 8'h46;
  localparam logic [CHAR_W-1:0] CH_ASCII_MAX = 8'h7F;

  // Classification of one character.
  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
    logic       is_plus;
    logic       is_under;
    logic       lead_bad;
  } char_info_t;

  // Per-string state visible outside the parser core.
  typedef struct packed {
    logic    at_first;
    logic    only_plus;
    status_t held;
  } core_state_t;

endpackage

>>> sv/rstu_char_decode.sv
// ----------------------------------------------------------------------------
// Character classifier
// Maps one byte to its digit value in the selected radix and flags the
// special characters.
// ----------------------------------------------------------------------------
module rstu_char_decode
  import rstu_pkg::*;
(
  input  logic [CHAR_W-1:0] char_i,
  input  radix_t            radix_i,
  output char_info_t        info_o
);

  logic [CHAR_W-1:0] raw_d;
  logic              is_num;
  logic              is_low;
  logic              is_up;
  logic              hex;
  logic              in_range;

  // Raw digit value before the radix range check.
  always_comb begin
    hex    = (radix_i == RADIX_HEX);
    is_num = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
    is_low = hex && (char_i >= CH_LOW_A) && (char_i <= CH_LOW_F);
    is_up  = hex && (char_i >= CH_UP_A) && (char_i <= CH_UP_F);
    if (is_num) begin
      raw_d = char_i - CH_ZERO;
    end else if (is_low) begin
      raw_d = char_i - CH_LOW_A + 8'd10;
    end else if (is_up) begin
      raw_d = char_i - CH_UP_A + 8'd10;
    end else begin
      raw_d = '0;
    end
  end

  // The digit must lie below the radix.
  always_comb begin
    case (radix_i)
      RADIX_BIN: in_range = (raw_d[3:1] == 3'd0);
      RADIX_OCT: in_range = (raw_d[3] == 1'b0);
      RADIX_DEC: in_range = (raw_d[3:0] < 4'd10);
      RADIX_HEX: in_range = 1'b1;
      default:   in_range = 1'b0;
    endcase
  end

  assign info_o.is_digit = (is_num || is_low || is_up) && in_range;
  assign info_o.digit    = raw_d[3:0];
  assign info_o.is_plus  = (char_i == CH_PLUS);
  assign info_o.is_under = (char_i == CH_UNDER);
  assign info_o.lead_bad = (char_i < CH_ZERO) || (char_i > CH_ASCII_MAX);

endmodule

>>> sv/rstu_core.sv
// ----------------------------------------------------------------------------
// Parser core
// Holds the per-string state and folds one classified character into the
// accumulator, producing the result on the last character or an empty item.
// ----------------------------------------------------------------------------
module rstu_core
  import rstu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take_i,
  input  char_info_t        info_i,
  input  logic              last_i,
  input  logic              empty_i,
  input  radix_t            radix_i,
  input  logic              wide_i,
  output logic              res_valid_o,
  output logic [ACC_W-1:0]  res_value_o,
  output status_t           res_status_o,
  output core_state_t       state_o
);

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  status_t           held_r, held_nxt;
  logic              first_r, first_nxt;
  logic              plus_r, plus_nxt;

  logic [PROD_W-1:0] acc_ext;
  logic [PROD_W-1:0] scaled;
  logic [PROD_W-1:0] prod;
  logic              over;
  logic [ACC_W-1:0]  acc_upd;
  status_t           st_upd;
  logic              first_upd;
  logic              plus_upd;
  status_t           st_fin;

  // Accumulator times the radix by shifts, then plus the digit.
  always_comb begin
    acc_ext = {4'd0, acc_r};
    case (radix_i)
      RADIX_BIN: scaled = acc_ext << 1;
      RADIX_OCT: scaled = acc_ext << 3;
      RADIX_DEC: scaled = (acc_ext << 3) + (acc_ext << 1);
      RADIX_HEX: scaled = acc_ext << 4;
      default:   scaled = (acc_ext << 3) + (acc_ext << 1);
    endcase
    prod = scaled + {{(PROD_W-4){1'b0}}, info_i.digit};
    if (wide_i) begin
      over = (prod[PROD_W-1:ACC_W] != '0);
    end else begin
      over = (prod[PROD_W-1:NARROW_W] != '0);
    end
  end

  // Take one character into the string state.
  always_comb begin
    acc_upd   = acc_r;
    st_upd    = held_r;
    first_upd = first_r;
    plus_upd  = plus_r;
    if (held_r == ST_OK) begin
      if (first_r && info_i.lead_bad) begin
        // A leading byte below the digits or above ASCII: only a plus that is not alone passes.
        first_upd = 1'b0;
        if (!info_i.is_plus || last_i) begin
          st_upd = ST_FORMAT;
        end else begin
          plus_upd = 1'b1;
        end
      end else begin
        first_upd = 1'b0;
        plus_upd  = 1'b0;
        if (!info_i.is_under) begin
          if (!info_i.is_digit) begin
            st_upd = ST_FORMAT;
          end else if (over) begin
            st_upd = ST_OVERFLOW;
          end else begin
            acc_upd = prod[ACC_W-1:0];
          end
        end
      end
    end
  end

  // Final status of a string that ends on this character.
  always_comb begin
    st_fin = st_upd;
    if (st_fin == ST_OK && plus_upd) begin
      st_fin = ST_FORMAT;
    end
    if (st_fin == ST_OK && !wide_i && acc_upd[ACC_W-1:NARROW_W] != '0) begin
      st_fin = ST_OVERFLOW;
    end
  end

  // Result and next state; a string end or empty item clears the state.
  always_comb begin
    res_valid_o  = take_i && (last_i || empty_i);
    res_status_o = empty_i ? ST_FORMAT : st_fin;
    res_value_o  = (!empty_i && st_fin == ST_OK) ? acc_upd : '0;
    acc_nxt   = acc_r;
    held_nxt  = held_r;
    first_nxt = first_r;
    plus_nxt  = plus_r;
    if (take_i) begin
      if (last_i || empty_i) begin
        acc_nxt   = '0;
        held_nxt  = ST_OK;
        first_nxt = 1'b1;
        plus_nxt  = 1'b0;
      end else begin
        acc_nxt   = acc_upd;
        held_nxt  = st_upd;
        first_nxt = first_upd;
        plus_nxt  = plus_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      held_r  <= ST_OK;
      first_r <= 1'b1;
      plus_r  <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      held_r  <= held_nxt;
      first_r <= first_nxt;
      plus_r  <= plus_nxt;
    end
  end

  assign state_o.at_first  = first_r;
  assign state_o.only_plus = plus_r;
  assign state_o.held      = held_r;

endmodule

>>> sv/radix_string_to_unsigned.sv
// ----------------------------------------------------------------------------
// Radix string to unsigned parser, top level
// Streams string characters in and gives one parsed value per string.
// ----------------------------------------------------------------------------
// Usage:
//   Each input request carries one character of a string in in_tdata, with
//   in_tlast on the final character and in_tuser set for an empty string.
//   One result request leaves per string: the value in out_tdata and the
//   status (ok, format error, overflow) in out_tuser; the value is zero
//   unless the status is ok.
//   The cfg channel sets the radix (index 0) and the 32/64-bit limit
//   (index 1); cfg_ready is always high, and writes belong between strings.
//   Throughput is one character per cycle while the output is not stalled.
//   A character passes an input register and then the parser core, and the
//   result is held in an output register. The rate is set by the accumulator
//   update, one shift-add and compare on a 68-bit word per cycle.
//   When the receiver stalls, the result holds in the output register and
//   one further character is still taken into the input register before
//   in_tready falls. Reset clears all string state and returns the radix
//   to decimal with the 32-bit limit.
// ----------------------------------------------------------------------------
`include "radix_string_to_unsigned_macros.svh"

module radix_string_to_unsigned
  import rstu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Input characters.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,   // [7:0] character
  input  logic              in_tlast,   // is_last
  input  logic [0:0]        in_tuser,   // [0] is_empty
  // Results.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [ACC_W-1:0]  out_tdata,  // [63:0] value
  output logic [1:0]        out_tuser,  // [1:0] status
  // Configuration writes.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [1:0]        cfg_data
);

  radix_t            radix_r, radix_nxt;
  logic              wide_r, wide_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_last_r;
  logic              s1_empty_r;

  logic              out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0]  out_value_r;
  status_t           out_status_r;

  logic              adv;
  logic              in_fire;
  logic              take;
  char_info_t        info;
  logic              res_valid;
  logic [ACC_W-1:0]  res_value;
  status_t           res_status;
  core_state_t       core_state;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_comb begin
    radix_nxt = radix_r;
    wide_nxt  = wide_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_RADIX: radix_nxt = radix_t'(cfg_data);
        CFG_WIDE:  wide_nxt  = cfg_data[0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_DEC;
      wide_r  <= 1'b0;
    end else begin
      radix_r <= radix_nxt;
      wide_r  <= wide_nxt;
    end
  end

  // The core advances whenever the output register is free or draining.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;
  assign take      = s1_valid_r && adv;

  // Input register.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r  <= in_tdata;
      s1_last_r  <= in_tlast;
      s1_empty_r <= in_tuser[0];
    end
  end

  // Character classification and string state.
  rstu_char_decode u_decode (
    .char_i  (s1_char_r),
    .radix_i (radix_r),
    .info_o  (info)
  );

  rstu_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .take_i       (take),
    .info_i       (info),
    .last_i       (s1_last_r),
    .empty_i      (s1_empty_r),
    .radix_i      (radix_r),
    .wide_i       (wide_r),
    .res_valid_o  (res_valid),
    .res_value_o  (res_value),
    .res_status_o (res_status),
    .state_o      (core_state)
  );

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  // Checks on the parser's own behaviour.
  `RSTU_ASSERT_SAME(a_err_value_zero, out_valid_r && out_status_r != ST_OK, out_value_r == '0, "value not zero on error")
  `RSTU_ASSERT_SAME(a_status_code, out_valid_r, out_tuser != 2'd3, "undefined status code")
  `RSTU_ASSERT_SAME(a_narrow_fits, out_valid_r && out_status_r == ST_OK && !wide_r, out_value_r[ACC_W-1:NARROW_W] == '0, "narrow result above limit")
  `RSTU_ASSERT_NEXT(a_string_clear, take && (s1_last_r || s1_empty_r), core_state.at_first && !core_state.only_plus && core_state.held == ST_OK, "string state not cleared")

endmodule
